### rtl/core/rmsn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsn_pkg
// Shared widths, constants, controller states and control/status bundles
// for the RMS normalizer.
// ----------------------------------------------------------------------------
package rmsn_pkg;

    localparam int DATA_W      = 16;
    localparam int EPS_W       = 16;
    localparam int SQ_W        = 31;
    localparam int SUM_W       = 43;
    localparam int MEAN_W      = 44;
    localparam int ROOT_W      = 22;
    localparam int SCALE_W     = 25;
    localparam int QUO_W       = 43;
    localparam int PROD1_W     = 42;
    localparam int PROD2_W     = 46;
    localparam int FRAC_W      = 12;
    localparam int RES_W       = PROD2_W - FRAC_W;
    localparam int DIV_CNT_W   = $clog2(QUO_W);
    localparam int SQRT_CNT_W  = $clog2(MEAN_W / 2);

    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(4096);
    localparam logic [SCALE_W-1:0] SCALE_SAT = SCALE_W'(1) << 24;
    localparam logic [EPS_W-1:0]   EPS_RESET = EPS_W'(168);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_MEAN_START,
        ST_DIV_MEAN,
        ST_SQRT,
        ST_DIV_REC,
        ST_MUL2,
        ST_OUT
    } rmsn_state_t;

    typedef struct packed {
        logic load_in;
        logic acc_add;
        logic mean_start;
        logic sqrt_start;
        logic rec_start;
        logic scale_load;
        logic mul2;
        logic out_load;
    } rmsn_cmd_t;

    typedef struct packed {
        logic last;
        logic div_busy;
        logic sqrt_busy;
    } rmsn_status_t;

endpackage
`default_nettype wire

### rtl/core/rmsn_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsn_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmsn_div
    import rmsn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [QUO_W-1:0]  dividend,
    input  wire logic [ROOT_W-1:0] divisor,
    output logic                   busy,
    output logic [QUO_W-1:0]       quotient
);

    logic                  busy_reg, busy_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [QUO_W-1:0]      quo_reg, quo_next;
    logic [ROOT_W-1:0]     rem_reg, rem_next;
    logic [ROOT_W-1:0]     dsr_reg, dsr_next;
    logic [ROOT_W:0]       trial;
    logic [ROOT_W:0]       diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[QUO_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(QUO_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[ROOT_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[ROOT_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

### rtl/core/rmsn_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsn_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module rmsn_sqrt
    import rmsn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [MEAN_W-1:0] radicand,
    output logic                   busy,
    output logic [ROOT_W-1:0]      root
);

    localparam int REM_W = ROOT_W + 2;

    logic                   busy_reg, busy_next;
    logic [SQRT_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MEAN_W-1:0]      n_reg, n_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [ROOT_W-1:0]      root_reg, root_next;
    logic [REM_W+1:0]       rem_sh;
    logic [REM_W+1:0]       trial;
    logic [REM_W+1:0]       diff;

    always_comb
    begin
        rem_sh    = {rem_reg, n_reg[MEAN_W-1 -: 2]};
        trial     = (REM_W + 2)'({root_reg, 2'b01});
        diff      = rem_sh - trial;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = SQRT_CNT_W'(ROOT_W - 1);
            n_next    = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            n_next = {n_reg[MEAN_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = diff[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

### rtl/core/rmsn_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsn_dp
// Datapath: square accumulation, mean/root/reciprocal chain through the
// shared divider and square root unit, and the two-multiply normalize path.
// ----------------------------------------------------------------------------
module rmsn_dp
    import rmsn_pkg::*;
#(
    parameter int MAX_LEN = 4096
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [EPS_W-1:0]         cfg_wr_data,
    input  wire logic signed [DATA_W-1:0] sample,
    input  wire logic signed [DATA_W-1:0] weight,
    input  wire logic                     last,
    input  wire rmsn_cmd_t                cmd,
    output rmsn_status_t                  status,
    output logic signed [DATA_W-1:0]      normalized,
    output logic                          saturated
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    logic [EPS_W-1:0]           eps_reg;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [SCALE_W-1:0]         scale_reg, scale_next;
    logic [SQ_W-1:0]            sq_reg;
    logic signed [DATA_W-1:0]   weight_reg;
    logic                       last_reg;
    logic signed [PROD1_W-1:0]  prod1_reg;
    logic signed [PROD2_W-1:0]  prod2_reg;
    logic signed [DATA_W-1:0]   norm_reg;
    logic                       sat_reg;

    logic signed [2*DATA_W-1:0] sq_full;
    logic signed [PROD1_W-1:0]  prod1_next;
    logic signed [PROD2_W-1:0]  prod2_next;
    logic signed [RES_W-1:0]    res;
    logic                       pos_ovf;
    logic                       neg_ovf;
    logic [SUM_W:0]             sum_add;

    logic                       div_start;
    logic [QUO_W-1:0]           div_dividend;
    logic [ROOT_W-1:0]          div_divisor;
    logic                       div_busy;
    logic [QUO_W-1:0]           quotient;
    logic [MEAN_W-1:0]          mean;
    logic                       sqrt_busy;
    logic [ROOT_W-1:0]          root;

    assign sq_full    = sample * sample;
    assign prod1_next = $signed({1'b0, scale_reg}) * sample;
    assign prod2_next = weight_reg * $signed(prod1_reg[PROD1_W-1:FRAC_W]);
    assign res        = $signed(prod2_reg[PROD2_W-1:FRAC_W]);
    assign pos_ovf    = !res[RES_W-1] && (|res[RES_W-2:DATA_W-1]);
    assign neg_ovf    = res[RES_W-1] && !(&res[RES_W-2:DATA_W-1]);
    assign sum_add    = {1'b0, sum_reg} + (SUM_W + 1)'(sq_reg);

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (cmd.acc_add && (count_reg < CNT_W'(MAX_LEN)))
        begin
            sum_next   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
            count_next = count_reg + 1'b1;
        end
        else if (cmd.mean_start)
        begin
            sum_next   = '0;
            count_next = '0;
        end
    end

    always_comb
    begin
        scale_next = scale_reg;
        if (cmd.scale_load)
        begin
            scale_next = (root == '0) ? SCALE_SAT : quotient[SCALE_W-1:0];
        end
    end

    // divider is shared: mean of squares, then reciprocal of the root
    always_comb
    begin
        div_start    = cmd.mean_start || cmd.rec_start;
        div_dividend = sum_reg;
        div_divisor  = (count_reg == '0) ? ROOT_W'(1) : ROOT_W'(count_reg);
        if (cmd.rec_start)
        begin
            div_dividend = QUO_W'(SCALE_SAT);
            div_divisor  = root;
        end
    end

    assign mean = MEAN_W'(quotient) + MEAN_W'(eps_reg);

    rmsn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    rmsn_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (mean),
        .busy     (sqrt_busy),
        .root     (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg   <= EPS_RESET;
            sum_reg   <= '0;
            count_reg <= '0;
            scale_reg <= SCALE_ONE;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                eps_reg <= cfg_wr_data;
            end
            sum_reg   <= sum_next;
            count_reg <= count_next;
            scale_reg <= scale_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sq_reg     <= sq_full[SQ_W-1:0];
            prod1_reg  <= prod1_next;
            weight_reg <= weight;
            last_reg   <= last;
        end
        if (cmd.mul2)
        begin
            prod2_reg <= prod2_next;
        end
        if (cmd.out_load)
        begin
            sat_reg <= pos_ovf || neg_ovf;
            if (pos_ovf)
            begin
                norm_reg <= {1'b0, {(DATA_W-1){1'b1}}};
            end
            else if (neg_ovf)
            begin
                norm_reg <= {1'b1, {(DATA_W-1){1'b0}}};
            end
            else
            begin
                norm_reg <= res[DATA_W-1:0];
            end
        end
    end

    assign status.last      = last_reg;
    assign status.div_busy  = div_busy;
    assign status.sqrt_busy = sqrt_busy;
    assign normalized       = norm_reg;
    assign saturated        = sat_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LEN))
        else $error("element count beyond MAX_LEN");

endmodule
`default_nettype wire

### rtl/core/rmsn_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmsn_ctrl
// Controller: input/output handshake and sequencing of the accumulate,
// vector close and normalize steps.
// ----------------------------------------------------------------------------
module rmsn_ctrl
    import rmsn_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         action,
    input  wire logic         out_stall,
    input  wire rmsn_status_t status,
    output logic              in_stall,
    output logic              out_valid,
    output rmsn_cmd_t         cmd
);

    rmsn_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = action ? ST_MUL2 : ST_ACC;
                end
            end
            ST_ACC:
            begin
                state_next = status.last ? ST_MEAN_START : ST_IDLE;
            end
            ST_MEAN_START:
            begin
                state_next = ST_DIV_MEAN;
            end
            ST_DIV_MEAN:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (!status.sqrt_busy)
                begin
                    state_next = ST_DIV_REC;
                end
            end
            ST_DIV_REC:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL2:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
            end
            ST_ACC:
            begin
                cmd.acc_add = 1'b1;
            end
            ST_MEAN_START:
            begin
                cmd.mean_start = 1'b1;
            end
            ST_DIV_MEAN:
            begin
                cmd.sqrt_start = !status.div_busy;
            end
            ST_SQRT:
            begin
                cmd.rec_start = !status.sqrt_busy;
            end
            ST_DIV_REC:
            begin
                cmd.scale_load = !status.div_busy;
            end
            ST_MUL2:
            begin
                cmd.mul2 = 1'b1;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mean_start || cmd.rec_start) |-> !status.div_busy)
        else $error("divider restarted while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("pending result overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sqrt_start |=> status.sqrt_busy)
        else $error("square root did not start");

endmodule
`default_nettype wire

### rtl/core/rms_normalizer.sv
// Accumulate item: accept, then add its square to the sum. Normalize item:
// accept, second multiply, saturate to the output register; that last step
// waits while the output stalls. Item marked last: before the next item is
// taken, the shared bit-serial divider forms the mean, the 22-step square root
// runs, then the divider forms the reciprocal. Each item is done before the next.
// Reset: sum and count cleared, scale 4096 (unity), epsilon 168, output empty.
`default_nettype none
// ----------------------------------------------------------------------------
// rms_normalizer
// Two-pass RMS normalization: accumulate squares, close the vector into an
// inverse-root scale, then scale and weight each sample.
// ----------------------------------------------------------------------------
module rms_normalizer
    import rmsn_pkg::*;
#(
    parameter int MAX_LEN = 4096
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [EPS_W-1:0]         cfg_wr_data,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     action,
    input  wire logic signed [DATA_W-1:0] sample,
    input  wire logic signed [DATA_W-1:0] weight,
    input  wire logic                     last,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [DATA_W-1:0]      normalized,
    output logic                          saturated
);

    rmsn_cmd_t    cmd;
    rmsn_status_t status;

    rmsn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .out_stall (out_stall),
        .status    (status),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    rmsn_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample      (sample),
        .weight      (weight),
        .last        (last),
        .cmd         (cmd),
        .status      (status),
        .normalized  (normalized),
        .saturated   (saturated)
    );

endmodule
`default_nettype wire

### tb/tb_rms_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rms_normalizer
// Self-checking bench for the RMS normalizer. Items are queued per phase and
// driven with random gaps; results are read with random stalls and checked
// against a fixed-point tracker of sum, count, epsilon and inverse-root scale.
// Phases cover directed extremes and random vector / normalize traffic under
// several epsilon settings.
// ----------------------------------------------------------------------------
module tb_rms_normalizer;
    import rmsn_pkg::*;

    localparam int     MAX_LEN       = 4096;
    localparam int     SETTLE_CYCLES = 150;
    localparam int     IDLE_LIMIT    = 4000;
    localparam logic   ACT_ACCUM     = 1'b0;
    localparam logic   ACT_NORM      = 1'b1;
    localparam longint RES_MAX       = 32767;
    localparam longint RES_MIN       = -32768;

    typedef struct packed {
        logic              act;
        logic [DATA_W-1:0] smp;
        logic [DATA_W-1:0] wgt;
        logic              lst;
    } element_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              sat;
    } norm_result_t;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     cfg_wr_en   = 1'b0;
    logic [EPS_W-1:0]         cfg_wr_data = '0;
    logic                     in_valid    = 1'b0;
    logic                     in_stall;
    logic                     action      = 1'b0;
    logic signed [DATA_W-1:0] sample      = '0;
    logic signed [DATA_W-1:0] weight      = '0;
    logic                     last        = 1'b0;
    logic                     out_valid;
    logic                     out_stall   = 1'b0;
    logic signed [DATA_W-1:0] normalized;
    logic                     saturated;

    rms_normalizer #(
        .MAX_LEN     (MAX_LEN)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .sample      (sample),
        .weight      (weight),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .normalized  (normalized),
        .saturated   (saturated)
    );

    always #2 clk = ~clk;

    // tracked block state
    logic [SUM_W-1:0]   sq_sum    = '0;
    int                 elem_cnt  = 0;
    logic [SCALE_W-1:0] inv_scale = SCALE_ONE;
    logic [EPS_W-1:0]   eps_reg   = EPS_RESET;

    element_t     element_q[$];
    norm_result_t normalized_q[$];
    element_t     next_elem;
    norm_result_t want;

    int error_count     = 0;
    int queued_items    = 0;
    int accepted_items  = 0;
    int results_checked = 0;
    int vectors_closed  = 0;
    int dropped_elems   = 0;
    int send_gap        = 0;
    int send_calm       = 0;
    int stall_left      = 0;
    int recv_calm       = 0;

    task automatic report_mismatch(input string msg);
        if (error_count < 40)
            $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned acc;
        longint unsigned trial;
        acc = 0;
        for (int b = 23; b >= 0; b--)
        begin
            trial = acc | (64'd1 << b);
            if (trial * trial <= n)
                acc = trial;
        end
        return acc;
    endfunction

    task automatic rmsnorm_track(input logic act, input logic signed [DATA_W-1:0] x,
                                 input logic signed [DATA_W-1:0] w, input logic lst);
        longint unsigned sq;
        longint unsigned total;
        longint unsigned cnt;
        longint unsigned mean;
        longint unsigned root;
        longint          scaled;
        longint          res;
        norm_result_t    r;
        if (act == ACT_ACCUM)
        begin
            if (elem_cnt < MAX_LEN)
            begin
                sq = longint'(x) * longint'(x);
                total = 64'(sq_sum) + sq;
                sq_sum = (total > 64'(SUM_MAX)) ? SUM_MAX : total[SUM_W-1:0];
                elem_cnt++;
            end
            else
                dropped_elems++;
            if (lst)
            begin
                cnt = (elem_cnt == 0) ? 1 : elem_cnt;
                mean = 64'(sq_sum) / cnt + 64'(eps_reg);
                root = int_sqrt(mean);
                inv_scale = (root == 0) ? SCALE_SAT : SCALE_W'(64'(SCALE_SAT) / root);
                sq_sum = '0;
                elem_cnt = 0;
                vectors_closed++;
            end
        end
        else
        begin
            scaled = (longint'(inv_scale) * longint'(x)) >>> FRAC_W;
            res = (longint'(w) * scaled) >>> FRAC_W;
            r.sat = 1'b0;
            if (res > RES_MAX)
            begin
                res = RES_MAX;
                r.sat = 1'b1;
            end
            else if (res < RES_MIN)
            begin
                res = RES_MIN;
                r.sat = 1'b1;
            end
            r.value = res[DATA_W-1:0];
            normalized_q.push_back(r);
        end
    endtask

    // mostly short gaps, a few long ones, and runs with none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2, 3:    return DATA_W'($urandom_range(0, 127)) - 16'd64;
            4:       return DATA_W'($urandom_range(0, 2)) - 16'd1;
            default: return DATA_W'($urandom());
        endcase
    endfunction

    task automatic push_item(input logic act, input logic [DATA_W-1:0] x,
                             input logic [DATA_W-1:0] w, input logic lst);
        element_t e;
        e.act = act;
        e.smp = x;
        e.wgt = w;
        e.lst = lst;
        element_q.push_back(e);
        queued_items++;
    endtask

    task automatic queue_directed();
        // scale one from reset; last is ignored on normalize
        push_item(ACT_NORM,  16'h7fff, 16'h7fff, 1'b0);
        push_item(ACT_NORM,  16'h8000, 16'h8000, 1'b0);
        push_item(ACT_NORM,  16'h8000, 16'h7fff, 1'b1);
        push_item(ACT_NORM,  16'h0001, 16'hffff, 1'b0);
        // single full-scale element
        push_item(ACT_ACCUM, 16'h8000, 16'h1234, 1'b1);
        push_item(ACT_NORM,  16'h7fff, 16'h7fff, 1'b0);
        push_item(ACT_NORM,  16'h8000, 16'h1000, 1'b0);
        push_item(ACT_NORM,  16'hffff, 16'h8000, 1'b0);
        // all-zero vector: epsilon alone sets the scale
        push_item(ACT_ACCUM, 16'h0000, 16'h0000, 1'b0);
        push_item(ACT_ACCUM, 16'h0000, 16'hffff, 1'b1);
        push_item(ACT_NORM,  16'h7fff, 16'h7fff, 1'b0);
        push_item(ACT_NORM,  16'h8000, 16'h7fff, 1'b0);
        push_item(ACT_NORM,  16'h0001, 16'h1000, 1'b1);
        push_item(ACT_NORM,  16'hffff, 16'hffff, 1'b0);
        push_item(ACT_NORM,  16'h0000, 16'h8000, 1'b0);
        push_item(ACT_ACCUM, 16'h1000, 16'h0000, 1'b0);
        push_item(ACT_ACCUM, 16'hf000, 16'h0000, 1'b0);
        push_item(ACT_ACCUM, 16'h7fff, 16'h0000, 1'b0);
        push_item(ACT_ACCUM, 16'h0001, 16'h0000, 1'b1);
        push_item(ACT_NORM,  16'h1000, 16'h1000, 1'b0);
        push_item(ACT_NORM,  16'hf000, 16'h7fff, 1'b0);
    endtask

    task automatic queue_random_traffic(input int target);
        int added;
        int len;
        added = 0;
        while (added < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 120)
                                                      : $urandom_range(1, 16);
                    for (int i = 1; i <= len; i++)
                        push_item(ACT_ACCUM, rand_word(), rand_word(), i == len);
                    added += len;
                    len = $urandom_range(1, 24);
                    for (int i = 0; i < len; i++)
                        push_item(ACT_NORM, rand_word(), rand_word(), $urandom_range(0, 7) == 0);
                    added += len;
                end
                6, 7:
                begin
                    len = $urandom_range(1, 12);
                    for (int i = 0; i < len; i++)
                        push_item(ACT_NORM, rand_word(), rand_word(), 1'($urandom_range(0, 1)));
                    added += len;
                end
                8:
                begin
                    len = $urandom_range(1, 8);
                    for (int i = 0; i < len; i++)
                        push_item(ACT_ACCUM, rand_word(), rand_word(), 1'b0);
                    added += len;
                end
                default:
                begin
                    len = $urandom_range(1, 10);
                    for (int i = 0; i < len; i++)
                        push_item(1'($urandom_range(0, 1)), rand_word(), rand_word(),
                                  $urandom_range(0, 3) == 0);
                    added += len;
                end
            endcase
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (accepted_items != queued_items || normalized_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_epsilon(input logic [EPS_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        eps_reg = v;
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (element_q.size() > 0)
            begin
                next_elem = element_q.pop_front();
                in_valid <= 1'b1;
                action   <= next_elem.act;
                sample   <= next_elem.smp;
                weight   <= next_elem.wgt;
                last     <= next_elem.lst;
                send_gap <= pick_gap(send_calm);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall  <= 1'b0;
            stall_left <= ($urandom_range(0, 3) == 0) ? pick_gap(recv_calm) : 0;
        end
    end

    // tracker update and result check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                rmsnorm_track(action, sample, weight, last);
                accepted_items++;
            end
            if (out_valid && !out_stall)
            begin
                if (normalized_q.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                begin
                    want = normalized_q.pop_front();
                    if (normalized !== want.value)
                        report_mismatch($sformatf("normalized %0d, expected %0d",
                                                  normalized, $signed(want.value)));
                    if (saturated !== want.sat)
                        report_mismatch($sformatf("saturated %0b, expected %0b",
                                                  saturated, want.sat));
                    results_checked++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        logic [EPS_W-1:0] eps_a;
        logic [EPS_W-1:0] eps_b;
        eps_a = EPS_W'($urandom_range(1, 65535));
        eps_b = EPS_W'($urandom_range(1, 65535));
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        queue_directed();
        wait_drained();

        set_epsilon(16'hffff);
        queue_random_traffic(250);
        wait_drained();

        set_epsilon(16'h0001);
        queue_random_traffic(250);
        wait_drained();

        set_epsilon(eps_a);
        queue_random_traffic(180);
        wait_drained();

        set_epsilon(eps_b);
        queue_random_traffic(180);
        wait_drained();

        set_epsilon(EPS_RESET);
        queue_random_traffic(180);
        wait_drained();

        if (normalized_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", normalized_q.size()));
        $display("Run: %0d items in, %0d results checked, %0d vectors closed",
                 accepted_items, results_checked, vectors_closed);
        $display("Epsilon 168, 65535, 1, %0d, %0d; %0d elements past max length dropped",
                 eps_a, eps_b, dropped_elems);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
